[hw/rtl/cbtc_pkg.sv]
// ----------------------------------------------------------------------------
// cbtc_pkg
// Shared widths, constants and record types for the CAN bit timing calculator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbtc_pkg;

  // field widths
  localparam int CLK_W  = 30;
  localparam int S1_W   = 9;
  localparam int S2_W   = 8;
  localparam int SJW_W  = 8;
  localparam int BRP_W  = 11;
  localparam int BR_W   = 23;
  localparam int SPT_W  = 10;
  localparam int QNS_W  = 32;
  localparam int RBR_W  = 24;

  // candidate loop widths
  localparam int T_W    = 11;
  localparam int H_W    = 10;
  localparam int PRE_W  = 31;
  localparam int ERR_W  = 32;

  // shared serial divider
  localparam int DIV_W  = 41;
  localparam int DVS_W  = 33;
  localparam int LEN_W  = 6;

  // prescaler granularity
  localparam int unsigned PRESCALER_STEP = 1;

  // recommended sample points and their bitrate bands
  localparam logic [SPT_W-1:0] SPT_FAST   = 10'd750;
  localparam logic [SPT_W-1:0] SPT_MID    = 10'd800;
  localparam logic [SPT_W-1:0] SPT_SLOW   = 10'd875;
  localparam logic [BR_W-1:0]  RATE_FAST  = 23'd800000;
  localparam logic [BR_W-1:0]  RATE_MID   = 23'd500000;
  localparam logic [SPT_W-1:0] SPT_SCALE  = 10'd1000;
  // error above 5.0 percent: floor(err * 1000 / rate) > 50
  localparam logic [5:0]       ERR_LIMIT  = 6'd51;
  localparam logic [CLK_W-1:0] NS_PER_S   = 30'd1000000000;
  localparam logic [ERR_W-1:0] WORST      = 32'hFFFF_FFFF;

  // register reset values
  localparam logic [CLK_W-1:0] CLOCK_RST  = 30'd144000000;
  localparam logic [S1_W-1:0]  S1MIN_RST  = 9'd1;
  localparam logic [S1_W-1:0]  S1MAX_RST  = 9'd16;
  localparam logic [S2_W-1:0]  S2MIN_RST  = 8'd1;
  localparam logic [S2_W-1:0]  S2MAX_RST  = 8'd8;
  localparam logic [SJW_W-1:0] SJWMAX_RST = 8'd4;
  localparam logic [BRP_W-1:0] BRPMIN_RST = 11'd1;
  localparam logic [BRP_W-1:0] BRPMAX_RST = 11'd64;

  // register indexes
  typedef enum logic [2:0] {
    REG_CLOCK_FREQ, REG_SEG1_MIN, REG_SEG1_MAX, REG_SEG2_MIN,
    REG_SEG2_MAX, REG_SJW_MAX, REG_BRP_MIN, REG_BRP_MAX
  } cbtc_reg_t;

  typedef struct packed {
    logic [CLK_W-1:0] clock_freq;
    logic [S1_W-1:0]  seg1_min;
    logic [S1_W-1:0]  seg1_max;
    logic [S2_W-1:0]  seg2_min;
    logic [S2_W-1:0]  seg2_max;
    logic [SJW_W-1:0] jump_width_max;
    logic [BRP_W-1:0] prescaler_min;
    logic [BRP_W-1:0] prescaler_max;
  } cbtc_cfg_t;

  typedef struct packed {
    logic [BR_W-1:0]  bitrate;
    logic [SPT_W-1:0] requested_sample_point;
    logic [SJW_W-1:0] requested_jump_width;
  } cbtc_req_t;

  typedef struct packed {
    logic             status;
    logic [BRP_W-1:0] prescaler;
    logic [QNS_W-1:0] quantum_ns;
    logic [7:0]       prop_segment;
    logic [8:0]       phase_segment1;
    logic [7:0]       phase_segment2;
    logic [SJW_W-1:0] jump_width;
    logic [SPT_W-1:0] real_sample_point;
    logic [RBR_W-1:0] real_bitrate;
  } cbtc_res_t;

endpackage

`default_nettype wire

[hw/rtl/cbtc_div.sv]
// ----------------------------------------------------------------------------
// cbtc_div
// Restoring radix-2 divider, one quotient bit per cycle over the low len
// bits of the dividend.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbtc_div
  import cbtc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  input  wire logic [LEN_W-1:0] len,
  output logic                  done,
  output logic [DIV_W-1:0]      quotient
);

  logic             busy_r;
  logic             done_r;
  logic [LEN_W-1:0] cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [DIV_W-1:0] quo_r;
  logic [DVS_W-1:0] dvs_r;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W+1:0] diff;
  logic             ge;
  logic [DVS_W-1:0] rem_nxt;

  // trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_W-1]};
    diff    = {1'b0, rem_sh} - {2'b00, dvs_r};
    ge      = !diff[DVS_W+1];
    rem_nxt = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
  end

  // iteration control; the dividend is aligned so its top used bit leads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= len;
        rem_r  <= '0;
        quo_r  <= dividend << (LEN_W'(DIV_W) - len);
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[DIV_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == LEN_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

[hw/rtl/cbtc_core.sv]
// ----------------------------------------------------------------------------
// cbtc_core
// Candidate search sequencer: walks the half-step segment counts, drives the
// shared serial divider and keeps the best timing found.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbtc_core
  import cbtc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cbtc_cfg_t cfg,
  input  wire logic      start,
  input  wire cbtc_req_t req,
  output logic           busy,
  output logic           res_valid,
  input  wire logic      res_take,
  output cbtc_res_t      res
);

  typedef enum logic [4:0] {
    S_IDLE, S_CAND, S_W_BRP, S_STEP, S_W_STEP, S_CHECK, S_RATE, S_W_RATE,
    S_SQ, S_W_SQ, S_SPLIT, S_W_SPT, S_EVAL, S_NEXT, S_FINAL, S_ERRCHK,
    S_QNS, S_W_Q, S_RESULT
  } state_t;

  state_t state_r;

  // request and loop registers
  logic [BR_W-1:0]  br_r;
  logic [SJW_W-1:0] sjw_req_r;
  logic [SPT_W-1:0] nom_r;
  logic [T_W-1:0]   t_r;
  logic [T_W-1:0]   lo_r;
  logic [PRE_W-1:0] brp_r;
  logic [CLK_W-1:0] rate_r;
  logic [CLK_W-1:0] rate_err_r;

  // best candidate so far
  logic             found_r;
  logic [ERR_W-1:0] best_rate_err_r;
  logic [ERR_W-1:0] pick_spt_err_r;
  logic [BRP_W-1:0] pick_brp_r;
  logic [CLK_W-1:0] best_rate_r;
  logic [S1_W-1:0]  best_s1_r;
  logic [H_W-1:0]   best_s2_r;
  logic [SPT_W-1:0] pick_spt_r;

  // segment split
  logic [H_W-1:0]   q_r;
  logic             i_r;
  logic [S1_W-1:0]  c1_r;
  logic [H_W-1:0]   c2_r;
  logic             have_r;
  logic [SPT_W-1:0] be_r;
  logic [SPT_W-1:0] bspt_r;
  logic [S1_W-1:0]  b1_r;
  logic [H_W-1:0]   b2_r;
  logic [SPT_W-1:0] fe_r;
  logic [SPT_W-1:0] fspt_r;
  logic [S1_W-1:0]  f1_r;
  logic [H_W-1:0]   f2_r;

  // final error check products
  logic [39:0]      err_scaled_r;
  logic [28:0]      err_limit_r;

  cbtc_res_t        res_r;

  // divider port
  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic [LEN_W-1:0] div_len;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;

  cbtc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .len      (div_len),
    .done     (div_done),
    .quotient (div_quo)
  );

  // candidate geometry
  logic [H_W-1:0]   half;
  logic [H_W-1:0]   tsegall;
  logic [T_W-1:0]   hi_calc;
  logic [T_W-1:0]   lo_calc;
  logic [SPT_W-1:0] nom_calc;

  always_comb begin
    half     = t_r[T_W-1:1];
    tsegall  = half + 1'b1;
    hi_calc  = {({1'b0, cfg.seg1_max} + {2'b00, cfg.seg2_max}), 1'b1};
    lo_calc  = {({1'b0, cfg.seg1_min} + {2'b00, cfg.seg2_min}), 1'b0};
    if (req.requested_sample_point != '0) begin
      nom_calc = req.requested_sample_point;
    end else if (req.bitrate > RATE_FAST) begin
      nom_calc = SPT_FAST;
    end else if (req.bitrate > RATE_MID) begin
      nom_calc = SPT_MID;
    end else begin
      nom_calc = SPT_SLOW;
    end
  end

  // segment two for the current split trial
  logic signed [11:0] v0;
  logic signed [11:0] v1;
  logic signed [11:0] v2;
  logic [H_W-1:0]     c2a;
  logic [H_W-1:0]     c1a;
  logic [S1_W-1:0]    c1s;
  logic [H_W-1:0]     c2s;
  logic [H_W-1:0]     spt_den;

  always_comb begin
    v0 = $signed({2'b00, tsegall}) - $signed({2'b00, q_r}) - $signed({11'd0, i_r});
    v1 = (v0 < $signed({4'd0, cfg.seg2_min})) ? $signed({4'd0, cfg.seg2_min}) : v0;
    v2 = (v1 > $signed({4'd0, cfg.seg2_max})) ? $signed({4'd0, cfg.seg2_max}) : v1;
    c2a = v2[H_W-1:0];
    if (c2a > half) begin
      c2a = half;
    end
    c1a = half - c2a;
    if (c1a > {1'b0, cfg.seg1_max}) begin
      c1s = cfg.seg1_max;
      c2s = half - {1'b0, cfg.seg1_max};
    end else begin
      c1s = c1a[S1_W-1:0];
      c2s = c2a;
    end
    spt_den = tsegall - c2s;
  end

  // rate and sample point errors
  logic [CLK_W-1:0] rate_q;
  logic [CLK_W-1:0] rate_err;
  logic [SPT_W-1:0] spt_q;
  logic [SPT_W-1:0] spt_e;
  logic [ERR_W-1:0] spt_err;
  logic [S1_W-1:0]  sel_s1;
  logic [H_W-1:0]   sel_s2;
  logic [SPT_W-1:0] sel_spt;

  always_comb begin
    rate_q   = div_quo[CLK_W-1:0];
    rate_err = ({7'd0, br_r} > rate_q) ? ({7'd0, br_r} - rate_q) : (rate_q - {7'd0, br_r});
    spt_q    = div_quo[SPT_W-1:0];
    spt_e    = (nom_r > spt_q) ? (nom_r - spt_q) : (spt_q - nom_r);
    if (have_r) begin
      spt_err = {22'd0, be_r};
      sel_s1  = b1_r;
      sel_s2  = b2_r;
      sel_spt = bspt_r;
    end else begin
      spt_err = WORST;
      sel_s1  = f1_r;
      sel_s2  = f2_r;
      sel_spt = fspt_r;
    end
  end

  // jump width clamp and quantum saturation for the result
  logic [SJW_W-1:0] sjw_lim;
  logic [SJW_W-1:0] sjw;
  logic [QNS_W-1:0] qns;

  always_comb begin
    sjw_lim = (sjw_req_r > cfg.jump_width_max) ? cfg.jump_width_max : sjw_req_r;
    if ({2'b00, sjw_lim} > best_s2_r) begin
      sjw_lim = best_s2_r[SJW_W-1:0];
    end
    if (sjw_req_r == '0 || cfg.jump_width_max == '0 || sjw_lim == '0) begin
      sjw = SJW_W'(1);
    end else begin
      sjw = sjw_lim;
    end
    qns = (div_quo[DIV_W-1:QNS_W] != '0) ? '1 : div_quo[QNS_W-1:0];
  end

  // divider operand selection
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    div_len      = '0;
    case (state_r)
      S_CAND: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(cfg.clock_freq);
        div_divisor  = DVS_W'(tsegall * br_r);
        div_len      = LEN_W'(CLK_W);
      end
      S_STEP: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(brp_r);
        div_divisor  = DVS_W'(PRESCALER_STEP);
        div_len      = LEN_W'(PRE_W);
      end
      S_RATE: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(cfg.clock_freq);
        div_divisor  = DVS_W'(brp_r[BRP_W-1:0] * tsegall);
        div_len      = LEN_W'(CLK_W);
      end
      S_SQ: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(nom_r * tsegall);
        div_divisor  = DVS_W'(SPT_SCALE);
        div_len      = LEN_W'(20);
      end
      S_SPLIT: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(spt_den * SPT_SCALE);
        div_divisor  = DVS_W'(tsegall);
        div_len      = LEN_W'(20);
      end
      S_QNS: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(pick_brp_r * NS_PER_S);
        div_divisor  = DVS_W'(cfg.clock_freq);
        div_len      = LEN_W'(DIV_W);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      found_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            br_r            <= req.bitrate;
            sjw_req_r       <= req.requested_jump_width;
            nom_r           <= nom_calc;
            t_r             <= hi_calc;
            lo_r            <= lo_calc;
            found_r         <= 1'b0;
            best_rate_err_r <= WORST;
            pick_spt_err_r  <= WORST;
            // error result until a timing is accepted
            res_r           <= cbtc_res_t'({1'b1, {($bits(cbtc_res_t)-1){1'b0}}});
            if (req.bitrate == '0 || cfg.clock_freq == '0 || hi_calc < lo_calc) begin
              state_r <= S_RESULT;
            end else begin
              state_r <= S_CAND;
            end
          end
        end
        S_CAND: begin
          state_r <= S_W_BRP;
        end
        S_W_BRP: begin
          if (div_done) begin
            brp_r   <= {1'b0, div_quo[CLK_W-1:0]} + PRE_W'(t_r[0]);
            state_r <= (PRESCALER_STEP > 1) ? S_STEP : S_CHECK;
          end
        end
        S_STEP: begin
          state_r <= S_W_STEP;
        end
        S_W_STEP: begin
          if (div_done) begin
            brp_r   <= PRE_W'(div_quo[PRE_W-1:0] * PRESCALER_STEP);
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (brp_r == '0 || brp_r < PRE_W'(cfg.prescaler_min)
              || brp_r > PRE_W'(cfg.prescaler_max)) begin
            state_r <= S_NEXT;
          end else begin
            state_r <= S_RATE;
          end
        end
        S_RATE: begin
          state_r <= S_W_RATE;
        end
        S_W_RATE: begin
          if (div_done) begin
            rate_r     <= rate_q;
            rate_err_r <= rate_err;
            if (ERR_W'(rate_err) > best_rate_err_r) begin
              state_r <= S_NEXT;
            end else begin
              if (ERR_W'(rate_err) < best_rate_err_r) begin
                pick_spt_err_r <= WORST;
              end
              state_r <= S_SQ;
            end
          end
        end
        S_SQ: begin
          state_r <= S_W_SQ;
        end
        S_W_SQ: begin
          if (div_done) begin
            q_r     <= div_quo[H_W-1:0];
            i_r     <= 1'b0;
            have_r  <= 1'b0;
            state_r <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          c1_r    <= c1s;
          c2_r    <= c2s;
          state_r <= S_W_SPT;
        end
        S_W_SPT: begin
          if (div_done) begin
            // nearest split at or below the wanted point
            if (spt_q <= nom_r && (!have_r || spt_e < be_r)) begin
              have_r <= 1'b1;
              be_r   <= spt_e;
              bspt_r <= spt_q;
              b1_r   <= c1_r;
              b2_r   <= c2_r;
            end
            // nearest split either way, kept as fallback
            if (!i_r || spt_e < fe_r) begin
              fe_r   <= spt_e;
              fspt_r <= spt_q;
              f1_r   <= c1_r;
              f2_r   <= c2_r;
            end
            if (!i_r) begin
              i_r     <= 1'b1;
              state_r <= S_SPLIT;
            end else begin
              state_r <= S_EVAL;
            end
          end
        end
        S_EVAL: begin
          if (spt_err > pick_spt_err_r) begin
            state_r <= S_NEXT;
          end else begin
            found_r         <= 1'b1;
            pick_spt_err_r  <= spt_err;
            best_rate_err_r <= ERR_W'(rate_err_r);
            pick_brp_r      <= brp_r[BRP_W-1:0];
            best_rate_r     <= rate_r;
            best_s1_r       <= sel_s1;
            best_s2_r       <= sel_s2;
            pick_spt_r      <= sel_spt;
            if (rate_err_r == '0 && spt_err == '0) begin
              state_r <= S_FINAL;
            end else begin
              state_r <= S_NEXT;
            end
          end
        end
        S_NEXT: begin
          if (t_r == lo_r) begin
            state_r <= S_FINAL;
          end else begin
            t_r     <= t_r - 1'b1;
            state_r <= S_CAND;
          end
        end
        S_FINAL: begin
          err_scaled_r <= best_rate_err_r[CLK_W-1:0] * SPT_SCALE;
          err_limit_r  <= br_r * ERR_LIMIT;
          state_r      <= found_r ? S_ERRCHK : S_RESULT;
        end
        S_ERRCHK: begin
          if (err_scaled_r >= {11'd0, err_limit_r}) begin
            state_r <= S_RESULT;
          end else begin
            state_r <= S_QNS;
          end
        end
        S_QNS: begin
          state_r <= S_W_Q;
        end
        S_W_Q: begin
          if (div_done) begin
            res_r.status            <= 1'b0;
            res_r.prescaler         <= pick_brp_r;
            res_r.quantum_ns        <= qns;
            res_r.prop_segment      <= best_s1_r[S1_W-1:1];
            res_r.phase_segment1    <= best_s1_r - {1'b0, best_s1_r[S1_W-1:1]};
            res_r.phase_segment2    <= best_s2_r[S2_W-1:0];
            res_r.jump_width        <= sjw;
            res_r.real_sample_point <= pick_spt_r;
            res_r.real_bitrate      <= best_rate_r[RBR_W-1:0];
            state_r                 <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (res_take) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign res_valid = (state_r == S_RESULT);
  assign res       = res_r;

endmodule

`default_nettype wire

[hw/rtl/can_bit_timing_calculator_top.sv]
// ----------------------------------------------------------------------------
// can_bit_timing_calculator_top
// CAN bit timing calculator: register file, request handshake and result
// output register around the candidate search core.
// ----------------------------------------------------------------------------
// Each fully evaluated candidate runs two 30-bit and three 20-bit divisions
// on one serial radix-2 divider, the 30-bit ones alone if it loses on rate,
// the first alone if out of prescaler range; one more for the quantum. Up to
// 2*(seg1_max+seg2_max-seg1_min-seg2_min)+2 candidates; one request at a time,
// the next accepted the cycle after the result moves to the output register.
// Reset: synchronous active-low, registers return to their default timing.
`timescale 1ns / 1ps
`default_nettype none

module can_bit_timing_calculator_top
  import cbtc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [CLK_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [BR_W-1:0]  in_bitrate,
  input  wire logic [SPT_W-1:0] in_requested_sample_point,
  input  wire logic [SJW_W-1:0] in_requested_jump_width,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_status,
  output logic [BRP_W-1:0]      out_prescaler,
  output logic [QNS_W-1:0]      out_quantum_ns,
  output logic [7:0]            out_prop_segment,
  output logic [8:0]            out_phase_segment1,
  output logic [7:0]            out_phase_segment2,
  output logic [SJW_W-1:0]      out_jump_width,
  output logic [SPT_W-1:0]      out_real_sample_point,
  output logic [RBR_W-1:0]      out_real_bitrate
);

  cbtc_cfg_t cfg_r;
  cbtc_req_t req;
  cbtc_res_t core_res;
  cbtc_res_t out_r;
  logic      out_valid_r;
  logic      core_busy;
  logic      core_res_valid;
  logic      res_take;
  logic      in_xfer;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clock_freq     <= CLOCK_RST;
      cfg_r.seg1_min       <= S1MIN_RST;
      cfg_r.seg1_max       <= S1MAX_RST;
      cfg_r.seg2_min       <= S2MIN_RST;
      cfg_r.seg2_max       <= S2MAX_RST;
      cfg_r.jump_width_max <= SJWMAX_RST;
      cfg_r.prescaler_min  <= BRPMIN_RST;
      cfg_r.prescaler_max  <= BRPMAX_RST;
    end else if (cfg_we) begin
      unique case (cbtc_reg_t'(cfg_index))
        REG_CLOCK_FREQ: cfg_r.clock_freq     <= cfg_data;
        REG_SEG1_MIN:   cfg_r.seg1_min       <= cfg_data[S1_W-1:0];
        REG_SEG1_MAX:   cfg_r.seg1_max       <= cfg_data[S1_W-1:0];
        REG_SEG2_MIN:   cfg_r.seg2_min       <= cfg_data[S2_W-1:0];
        REG_SEG2_MAX:   cfg_r.seg2_max       <= cfg_data[S2_W-1:0];
        REG_SJW_MAX:    cfg_r.jump_width_max <= cfg_data[SJW_W-1:0];
        REG_BRP_MIN:    cfg_r.prescaler_min  <= cfg_data[BRP_W-1:0];
        REG_BRP_MAX:    cfg_r.prescaler_max  <= cfg_data[BRP_W-1:0];
        default:        cfg_r                <= cfg_r;
      endcase
    end
  end

  // request transfer
  assign in_stall = core_busy;
  assign in_xfer  = in_valid && !core_busy;

  always_comb begin
    req.bitrate                = in_bitrate;
    req.requested_sample_point = in_requested_sample_point;
    req.requested_jump_width   = in_requested_jump_width;
  end

  cbtc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (in_xfer),
    .req       (req),
    .busy      (core_busy),
    .res_valid (core_res_valid),
    .res_take  (res_take),
    .res       (core_res)
  );

  // output register, loaded when empty or being drained
  assign res_take = core_res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
      out_r       <= core_res;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_r.status;
  assign out_prescaler         = out_r.prescaler;
  assign out_quantum_ns        = out_r.quantum_ns;
  assign out_prop_segment      = out_r.prop_segment;
  assign out_phase_segment1    = out_r.phase_segment1;
  assign out_phase_segment2    = out_r.phase_segment2;
  assign out_jump_width        = out_r.jump_width;
  assign out_real_sample_point = out_r.real_sample_point;
  assign out_real_bitrate      = out_r.real_bitrate;

endmodule

`default_nettype wire

[verif/tb_can_bit_timing_calculator_top.sv]
// ----------------------------------------------------------------------------
// tb_can_bit_timing_calculator_top
// Self-checking bench for the CAN bit timing calculator. Each accepted
// request is run through an in-bench timing search that works out the
// expected timing result. Results are compared field by field in arrival
// order. The run covers several register settings, the field extremes and
// random requests, under random, long and no receiver back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_can_bit_timing_calculator_top
  import cbtc_pkg::*;
();

  localparam int unsigned NO_SPLIT   = 32'hFFFF_FFFF;
  localparam int          SETTLE     = 40;
  localparam longint      CYCLE_CAP  = 40_000_000;
  localparam int          HOLD_LEN   = 30000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [2:0]       cfg_index = '0;
  logic [CLK_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [BR_W-1:0]  in_bitrate = '0;
  logic [SPT_W-1:0] in_requested_sample_point = '0;
  logic [SJW_W-1:0] in_requested_jump_width = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_status;
  logic [BRP_W-1:0] out_prescaler;
  logic [QNS_W-1:0] out_quantum_ns;
  logic [7:0]       out_prop_segment;
  logic [8:0]       out_phase_segment1;
  logic [7:0]       out_phase_segment2;
  logic [SJW_W-1:0] out_jump_width;
  logic [SPT_W-1:0] out_real_sample_point;
  logic [RBR_W-1:0] out_real_bitrate;

  cbtc_cfg_t  timing_regs;
  cbtc_res_t  timing_queue[$];
  int         mismatches = 0;
  longint     cycle_count = 0;
  int         send_gap_pct = 0;
  int         recv_stall_pct = 0;
  bit         hold_request = 1'b0;
  int         hold_left = 0;

  can_bit_timing_calculator_top uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_bitrate(in_bitrate),
    .in_requested_sample_point(in_requested_sample_point),
    .in_requested_jump_width(in_requested_jump_width),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_prescaler(out_prescaler),
    .out_quantum_ns(out_quantum_ns), .out_prop_segment(out_prop_segment),
    .out_phase_segment1(out_phase_segment1),
    .out_phase_segment2(out_phase_segment2),
    .out_jump_width(out_jump_width),
    .out_real_sample_point(out_real_sample_point),
    .out_real_bitrate(out_real_bitrate)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("can_bit_timing_calculator_top: mismatch");
      $finish;
    end
  end

  // split of tseg quanta into segments for a wanted sample point
  function automatic int unsigned split_quanta(input int unsigned nom,
                                               input int unsigned tseg,
                                               output int unsigned s1,
                                               output int unsigned s2,
                                               output int unsigned err);
    int unsigned n, best_e, keep_spt, b1, b2, fb_e, fb_spt, f1, f2;
    int unsigned c1, c2, spt, e;
    int v;
    bit have;
    n = tseg + 1;
    best_e = NO_SPLIT; keep_spt = 0; b1 = 0; b2 = 0; have = 0;
    fb_e = 0; fb_spt = 0; f1 = 0; f2 = 0;
    for (int i = 0; i <= 1; i++) begin
      v = int'(n) - int'((nom * n) / 1000) - i;
      if (v < int'(timing_regs.seg2_min)) v = int'(timing_regs.seg2_min);
      if (v > int'(timing_regs.seg2_max)) v = int'(timing_regs.seg2_max);
      c2 = v;
      if (c2 > tseg) c2 = tseg;
      c1 = tseg - c2;
      if (c1 > timing_regs.seg1_max) begin
        c1 = timing_regs.seg1_max;
        c2 = tseg - c1;
      end
      spt = (1000 * (n - c2)) / n;
      e = (nom > spt) ? nom - spt : spt - nom;
      if (spt <= nom && e < best_e) begin
        have = 1; best_e = e; keep_spt = spt; b1 = c1; b2 = c2;
      end
      if (i == 0 || e < fb_e) begin
        fb_e = e; fb_spt = spt; f1 = c1; f2 = c2;
      end
    end
    if (!have) begin
      s1 = f1; s2 = f2; err = NO_SPLIT;
      return fb_spt;
    end
    s1 = b1; s2 = b2; err = best_e;
    return keep_spt;
  endfunction

  // expected bit timing for one request under the current registers
  function automatic cbtc_res_t predict_timing(input cbtc_req_t req);
    cbtc_res_t res;
    longint unsigned clk_hz, rate_req, brp, q;
    int unsigned nom, half, tsegall, rate, rate_err, spt_err;
    int unsigned best_rate_err, pick_spt_err, pick_tseg, pick_brp;
    int unsigned s1, s2, spt, sjw;
    int hi, lo;
    bit found;
    res = '0;
    res.status = 1'b1;
    clk_hz = timing_regs.clock_freq;
    rate_req = req.bitrate;
    if (rate_req == 0 || clk_hz == 0) return res;
    if (req.requested_sample_point != 0) nom = req.requested_sample_point;
    else if (rate_req > 800000) nom = 750;
    else if (rate_req > 500000) nom = 800;
    else nom = 875;
    best_rate_err = NO_SPLIT; pick_spt_err = NO_SPLIT;
    pick_tseg = 0; pick_brp = 0; s1 = 0; s2 = 0; found = 0;
    hi = (int'(timing_regs.seg1_max) + int'(timing_regs.seg2_max)) * 2 + 1;
    lo = (int'(timing_regs.seg1_min) + int'(timing_regs.seg2_min)) * 2;
    for (int t = hi; t >= lo; t--) begin
      half = t / 2;
      tsegall = 1 + half;
      brp = clk_hz / (longint'(tsegall) * rate_req) + (t & 1);
      brp = (brp / PRESCALER_STEP) * PRESCALER_STEP;
      if (brp == 0 || brp < timing_regs.prescaler_min ||
          brp > timing_regs.prescaler_max) continue;
      rate = clk_hz / (brp * tsegall);
      rate_err = (rate_req > rate) ? rate_req - rate : rate - rate_req;
      if (rate_err > best_rate_err) continue;
      if (rate_err < best_rate_err) pick_spt_err = NO_SPLIT;
      void'(split_quanta(nom, half, s1, s2, spt_err));
      if (spt_err > pick_spt_err) continue;
      found = 1;
      pick_spt_err = spt_err; best_rate_err = rate_err;
      pick_tseg = half; pick_brp = brp;
      if (rate_err == 0 && spt_err == 0) break;
    end
    if (!found) return res;
    if ((longint'(best_rate_err) * 1000) / rate_req > 50) return res;
    spt = split_quanta(nom, pick_tseg, s1, s2, pick_spt_err);
    q = (longint'(pick_brp) * 64'd1000000000) / clk_hz;
    if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
    if (req.requested_jump_width == 0 || timing_regs.jump_width_max == 0) begin
      sjw = 1;
    end else begin
      sjw = (req.requested_jump_width > timing_regs.jump_width_max) ?
            timing_regs.jump_width_max : req.requested_jump_width;
      if (s2 < sjw) sjw = s2;
      if (sjw == 0) sjw = 1;
    end
    res.status            = 1'b0;
    res.prescaler         = pick_brp;
    res.quantum_ns        = q;
    res.prop_segment      = s1 / 2;
    res.phase_segment1    = s1 - s1 / 2;
    res.phase_segment2    = s2;
    res.jump_width        = sjw;
    res.real_sample_point = spt;
    res.real_bitrate      = clk_hz / (longint'(pick_brp) * (1 + s1 + s2));
    return res;
  endfunction

  // receiver back-pressure, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t %s: expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // result checker, payload sampled mid-cycle before the transfer edge
  always @(negedge clk) begin
    cbtc_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (timing_queue.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: expected none actual status %0d",
                 $time, out_status);
      end else begin
        want = timing_queue.pop_front();
        check_field("status", want.status, out_status);
        check_field("prescaler", want.prescaler, out_prescaler);
        check_field("quantum_ns", want.quantum_ns, out_quantum_ns);
        check_field("prop_segment", want.prop_segment, out_prop_segment);
        check_field("phase_segment1", want.phase_segment1, out_phase_segment1);
        check_field("phase_segment2", want.phase_segment2, out_phase_segment2);
        check_field("jump_width", want.jump_width, out_jump_width);
        check_field("real_sample_point", want.real_sample_point,
                    out_real_sample_point);
        check_field("real_bitrate", want.real_bitrate, out_real_bitrate);
      end
    end
  end

  // one request transfer, then a random sender gap
  task automatic send_request(input cbtc_req_t req);
    bit taken;
    in_valid <= 1'b1;
    in_bitrate <= req.bitrate;
    in_requested_sample_point <= req.requested_sample_point;
    in_requested_jump_width <= req.requested_jump_width;
    taken = 0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    timing_queue.push_back(predict_timing(req));
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      while ($urandom_range(99) < send_gap_pct) @(posedge clk);
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (timing_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register write sequence, only with the block idle
  task automatic load_registers(input cbtc_cfg_t c);
    drain_results();
    cfg_we <= 1'b1;
    for (int i = 0; i < 8; i++) begin
      cfg_index <= i[2:0];
      case (cbtc_reg_t'(i))
        REG_CLOCK_FREQ: cfg_data <= c.clock_freq;
        REG_SEG1_MIN:   cfg_data <= c.seg1_min;
        REG_SEG1_MAX:   cfg_data <= c.seg1_max;
        REG_SEG2_MIN:   cfg_data <= c.seg2_min;
        REG_SEG2_MAX:   cfg_data <= c.seg2_max;
        REG_SJW_MAX:    cfg_data <= c.jump_width_max;
        REG_BRP_MIN:    cfg_data <= c.prescaler_min;
        default:        cfg_data <= c.prescaler_max;
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    timing_regs = c;
  endtask

  function automatic cbtc_cfg_t timing_set(input int unsigned hz,
      input int unsigned s1lo, input int unsigned s1hi,
      input int unsigned s2lo, input int unsigned s2hi,
      input int unsigned sjw, input int unsigned plo, input int unsigned phi);
    cbtc_cfg_t c;
    c.clock_freq = hz; c.seg1_min = s1lo; c.seg1_max = s1hi;
    c.seg2_min = s2lo; c.seg2_max = s2hi; c.jump_width_max = sjw;
    c.prescaler_min = plo; c.prescaler_max = phi;
    return c;
  endfunction

  function automatic cbtc_req_t make_req(input int unsigned rate,
                                         input int unsigned spt,
                                         input int unsigned sjw);
    cbtc_req_t r;
    r.bitrate = rate; r.requested_sample_point = spt;
    r.requested_jump_width = sjw;
    return r;
  endfunction

  // mostly common bus rates with sensible sample points, some noise
  function automatic cbtc_req_t random_req();
    int unsigned common_rates[10] = '{10000, 20000, 50000, 100000, 125000,
                                      250000, 500000, 800000, 1000000, 2000000};
    int unsigned rate, spt;
    if ($urandom_range(99) < 70) begin
      rate = common_rates[$urandom_range(9)];
      if ($urandom_range(3) == 0) rate = rate + $urandom_range(2000) - 1000;
      spt = ($urandom_range(1) == 0) ? 0 : $urandom_range(999, 600);
    end else begin
      rate = $urandom_range(8000000);
      spt = $urandom_range(999);
    end
    return make_req(rate, spt, $urandom_range(128));
  endfunction

  // reset register values
  task automatic test_reset_defaults();
    timing_regs = timing_set(CLOCK_RST, S1MIN_RST, S1MAX_RST, S2MIN_RST,
                             S2MAX_RST, SJWMAX_RST, BRPMIN_RST, BRPMAX_RST);
    send_request(make_req(500000, 0, 1));
    send_request(make_req(1000000, 0, 4));
  endtask

  // field extremes, recommended sample point bands, jump width cases
  task automatic test_field_extremes();
    send_request(make_req(0, 800, 2));
    send_request(make_req(1, 0, 0));
    send_request(make_req(8000000, 999, 128));
    send_request(make_req(500000, 0, 3));
    send_request(make_req(500001, 0, 3));
    send_request(make_req(800000, 0, 2));
    send_request(make_req(800001, 0, 2));
    send_request(make_req(250000, 1, 5));
    send_request(make_req(125000, 999, 128));
    send_request(make_req(7340031, 1023 - 24, 127));
    send_request(make_req(4194304, 512, 64));
  endtask

  // register corner settings
  task automatic test_register_corners();
    // jump width limit zero and segment two forced to its minimum
    load_registers(timing_set(80000000, 1, 10, 2, 5, 0, 1, 32));
    send_request(make_req(1000000, 0, 8));
    send_request(make_req(500000, 990, 3));
    // inverted segment two and prescaler limits
    load_registers(timing_set(80000000, 2, 8, 6, 3, 8, 1, 40));
    send_request(make_req(1000000, 500, 4));
    load_registers(timing_set(80000000, 2, 8, 1, 4, 8, 40, 10));
    send_request(make_req(500000, 0, 2));
    // slowest clock, no usable prescaler
    load_registers(timing_set(1, 1, 4, 1, 2, 2, 1, 8));
    send_request(make_req(1, 0, 1));
    send_request(make_req(100000, 0, 1));
    // fastest clock, widest limits, saturating prescaler range
    load_registers(timing_set(1000000000, 256, 256, 128, 128, 128, 1024, 1024));
    send_request(make_req(1, 500, 128));
    load_registers(timing_set(1000000000, 1, 256, 1, 128, 128, 1, 1024));
    send_request(make_req(8000000, 0, 128));
    send_request(make_req(1000, 875, 100));
  endtask

  // random requests under varying small register settings
  task automatic test_random_requests(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 25 == 0)
        load_registers(timing_set(
          ($urandom_range(3) == 0) ? $urandom_range(1000000000, 1) :
                                     $urandom_range(40, 8) * 2000000,
          $urandom_range(3, 1), $urandom_range(10, 4),
          $urandom_range(2, 1), $urandom_range(5, 2),
          $urandom_range(8), $urandom_range(3, 1), $urandom_range(1024, 16)));
      send_request(random_req());
    end
  endtask

  // long receiver hold-off, then a full pause of the sender
  task automatic test_back_pressure();
    load_registers(timing_set(40000000, 1, 8, 1, 4, 4, 1, 64));
    hold_request = 1'b1;
    for (int i = 0; i < 6; i++) send_request(random_req());
    drain_results();
    send_request(make_req(250000, 0, 2));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_gap_pct = 7;
    recv_stall_pct = 75;
    test_reset_defaults();
    test_field_extremes();
    test_register_corners();
    test_random_requests(100);
    send_gap_pct = 75;
    recv_stall_pct = 7;
    test_random_requests(100);
    test_back_pressure();
    send_gap_pct = 0;
    recv_stall_pct = 0;
    test_random_requests(100);
    drain_results();
    if (mismatches == 0) begin
      $display("can_bit_timing_calculator_top: match");
    end else begin
      $display("can_bit_timing_calculator_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
